// ===== hdl/htm_pkg.sv =====
// Shared types, constants and tables of the transform matrix generator.
package htm_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [3:0] ACT_MOVE_L    = 4'd0;
    localparam logic [3:0] ACT_MOVE_R    = 4'd1;
    localparam logic [3:0] ACT_MOVE_U    = 4'd2;
    localparam logic [3:0] ACT_MOVE_D    = 4'd3;
    localparam logic [3:0] ACT_MOVE_B    = 4'd4;
    localparam logic [3:0] ACT_MOVE_F    = 4'd5;
    localparam logic [3:0] ACT_SCALE     = 4'd6;
    localparam logic [3:0] ACT_ROT_CW_X  = 4'd7;
    localparam logic [3:0] ACT_ROT_ACW_X = 4'd8;
    localparam logic [3:0] ACT_ROT_CW_Y  = 4'd9;
    localparam logic [3:0] ACT_ROT_ACW_Y = 4'd10;
    localparam logic [3:0] ACT_ROT_CW_Z  = 4'd11;
    localparam logic [3:0] ACT_ROT_ACW_Z = 4'd12;

    // Pi in Q30 and the CORDIC gain in Q30.
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam int          Q30      = 30;

    // floor(pi * 2^(30+F+7) / (180 * 2^F)); the fraction width cancels out.
    localparam logic [31:0] RAD_RECIP = 32'((64'd3373259426 * 64'd128) / 64'd180);

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] value;
    } t_side;

    typedef struct packed {
        t_side side;
        logic  neg;
        logic  cos_neg;
    } t_ang;

    typedef struct packed {
        t_side              side;
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } t_res;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd843314856;
            1:       v = 32'd497837829;
            2:       v = 32'd263043836;
            3:       v = 32'd133525158;
            4:       v = 32'd67021686;
            5:       v = 32'd33543515;
            6:       v = 32'd16775850;
            7:       v = 32'd8388437;
            8:       v = 32'd4194282;
            9:       v = 32'd2097149;
            10:      v = 32'd1048575;
            11:      v = 32'd524287;
            12:      v = 32'd262143;
            13:      v = 32'd131071;
            14:      v = 32'd65535;
            15:      v = 32'd32767;
            16:      v = 32'd16383;
            17:      v = 32'd8191;
            18:      v = 32'd4095;
            19:      v = 32'd2047;
            20:      v = 32'd1023;
            21:      v = 32'd511;
            22:      v = 32'd255;
            23:      v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/htm_reduce.sv =====
// Angle reduction modulo 360 degrees and folding into the first quadrant.
module htm_reduce #(
    parameter int FRAC_BITS = htm_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  htm_pkg::t_side       i_side,
    output logic                 o_vld,
    output htm_pkg::t_ang        o_ang,
    output logic [FRAC_BITS+6:0] o_mag
);

    localparam int QW     = 32 - FRAC_BITS;
    localparam int UW     = QW + 1;
    localparam int RW     = UW - 8;
    localparam int OFFS   = 360 * (((2 ** (QW - 1)) + 359) / 360);
    localparam int RECIP  = (2 ** UW) / 360;
    localparam int AW     = FRAC_BITS + 9;
    localparam logic [RW-1:0]        RECIP_V = RW'(RECIP);
    localparam logic [AW-1:0]        DEG360  = AW'(360) << FRAC_BITS;
    localparam logic [AW-1:0]        DEG180W = AW'(180) << FRAC_BITS;
    localparam logic [FRAC_BITS+7:0] DEG180  = (FRAC_BITS + 8)'(180) << FRAC_BITS;
    localparam logic [FRAC_BITS+7:0] DEG90   = (FRAC_BITS + 8)'(90) << FRAC_BITS;

    logic [5:0]               r_vld;
    htm_pkg::t_side           r_side [5];
    logic                     r5_neg;
    logic [UW-1:0]            r1_u, r2_u, r3_u;
    logic [FRAC_BITS-1:0]     r1_frac, r2_frac, r3_frac, r4_frac;
    logic [UW+RW-1:0]         r2_p;
    logic [UW:0]              r3_m;
    logic [8:0]               r4_rem;
    logic [FRAC_BITS+7:0]     r5_m0;
    htm_pkg::t_ang            r_ang;
    logic [FRAC_BITS+6:0]     r_mag;

    logic [QW-1:0]            w_q;
    logic [UW-1:0]            n_u;
    logic [RW-1:0]            w_qe;
    logic [UW:0]              w_diff;
    logic [9:0]               w_rem;
    logic [8:0]               n_rem;
    logic [AW-1:0]            w_r;
    logic [AW-1:0]            w_rneg;
    logic [FRAC_BITS+7:0]     n_m0;
    logic                     n_neg;
    logic [FRAC_BITS+7:0]     w_fold;
    logic [FRAC_BITS+6:0]     n_mag;
    logic                     n_cos_neg;

    assign w_q    = i_side.value[31:FRAC_BITS];
    assign n_u    = {w_q[QW-1], w_q} + UW'(OFFS);
    assign w_qe   = r2_p[UW+RW-1:UW];
    assign w_diff = {1'b0, r3_u} - r3_m;
    assign w_rem  = w_diff[9:0];
    assign n_rem  = (w_rem >= 10'd360) ? 9'(w_rem - 10'd360) : w_rem[8:0];
    assign w_r    = {r4_rem, r4_frac};
    assign w_rneg = DEG360 - w_r;

    always_comb begin
        if (w_r < DEG180W) begin
            n_neg = 1'b0;
            n_m0  = w_r[FRAC_BITS+7:0];
        end else begin
            n_neg = 1'b1;
            n_m0  = w_rneg[FRAC_BITS+7:0];
        end
    end

    assign w_fold = DEG180 - r5_m0;

    always_comb begin
        if (r5_m0 > DEG90) begin
            n_cos_neg = 1'b1;
            n_mag     = w_fold[FRAC_BITS+6:0];
        end else begin
            n_cos_neg = 1'b0;
            n_mag     = r5_m0[FRAC_BITS+6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r1_u      <= n_u;
            r1_frac   <= i_side.value[FRAC_BITS-1:0];

            r_side[1] <= r_side[0];
            r2_p      <= (UW + RW)'(r1_u) * (UW + RW)'(RECIP_V);
            r2_u      <= r1_u;
            r2_frac   <= r1_frac;

            r_side[2] <= r_side[1];
            r3_m      <= (UW + 1)'(w_qe) * (UW + 1)'(360);
            r3_u      <= r2_u;
            r3_frac   <= r2_frac;

            r_side[3] <= r_side[2];
            r4_rem    <= n_rem;
            r4_frac   <= r3_frac;

            r_side[4] <= r_side[3];
            r5_m0     <= n_m0;
            r5_neg    <= n_neg;

            r_ang.side    <= r_side[4];
            r_ang.neg     <= r5_neg;
            r_ang.cos_neg <= n_cos_neg;
            r_mag         <= n_mag;
        end
    end

    assign o_vld = r_vld[5];
    assign o_ang = r_ang;
    assign o_mag = r_mag;

endmodule

// ===== hdl/htm_rad.sv =====
// Conversion of the folded angle from degrees to Q30 radians.
module htm_rad #(
    parameter int FRAC_BITS = htm_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  htm_pkg::t_ang        i_ang,
    input  logic [FRAC_BITS+6:0] i_mag,
    output logic                 o_vld,
    output htm_pkg::t_ang        o_ang,
    output logic [30:0]          o_z
);

    localparam int MW = FRAC_BITS + 7;
    localparam int PW = MW + 32;

    logic [3:0]         r_vld;
    htm_pkg::t_ang      r_ang [4];
    logic [MW-1:0]      r1_mag;
    logic [PW-1:0]      r1_prod;
    logic [31:0]        r2_zc, r3_zc;
    logic [PW-1:0]      r2_pr, r3_pr;
    logic [40:0]        r3_chk;
    logic [30:0]        r4_z;

    logic [31:0]        w_zp1;
    logic [PW+1:0]      w_lhs;
    logic [30:0]        n_z;

    assign w_zp1 = r3_zc + 32'd1;
    assign w_lhs = {r3_chk, {FRAC_BITS{1'b0}}};
    assign n_z   = (w_lhs <= {2'b00, r3_pr}) ? w_zp1[30:0] : r3_zc[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang[0] <= i_ang;
            r1_mag   <= i_mag;
            r1_prod  <= PW'(i_mag) * PW'(htm_pkg::RAD_RECIP);

            r_ang[1] <= r_ang[0];
            r2_zc    <= r1_prod[PW-1:MW];
            r2_pr    <= PW'(r1_mag) * PW'(htm_pkg::PI_Q30);

            r_ang[2] <= r_ang[1];
            r3_zc    <= r2_zc;
            r3_pr    <= r2_pr;
            r3_chk   <= 41'({1'b0, r2_zc} + 33'd1) * 41'd180;

            r_ang[3] <= r_ang[2];
            r4_z     <= n_z;
        end
    end

    assign o_vld = r_vld[3];
    assign o_ang = r_ang[3];
    assign o_z   = r4_z;

endmodule

// ===== hdl/htm_cordic.sv =====
// Pipelined rotation-mode CORDIC giving signed sine and cosine.
module htm_cordic #(
    parameter int FRAC_BITS     = htm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = htm_pkg::CORDIC_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  htm_pkg::t_ang i_ang,
    input  logic [30:0]   i_z,
    output logic          o_vld,
    output htm_pkg::t_res o_res
);

    localparam int N  = CORDIC_STAGES;
    localparam int XW = 34;
    localparam int ZW = 33;
    localparam int SH = htm_pkg::Q30 - FRAC_BITS;
    localparam logic signed [XW-1:0] GAIN = XW'(htm_pkg::GAIN_Q30);
    localparam logic signed [XW-1:0] HALF = XW'(1) << (SH - 1);

    logic signed [XW-1:0] r_x [N];
    logic signed [XW-1:0] r_y [N];
    logic signed [ZW-1:0] r_z [N];
    logic                 r_vld [N];
    htm_pkg::t_ang        r_ang [N];

    genvar gi;
    for (gi = 0; gi < N; gi++) begin : g_stage
        logic signed [XW-1:0] w_xi;
        logic signed [XW-1:0] w_yi;
        logic signed [ZW-1:0] w_zi;
        logic                 w_vi;
        htm_pkg::t_ang        w_ai;
        logic signed [ZW-1:0] w_at;

        if (gi == 0) begin : g_head
            assign w_xi = GAIN;
            assign w_yi = '0;
            assign w_zi = $signed({2'b00, i_z});
            assign w_vi = i_vld;
            assign w_ai = i_ang;
        end else begin : g_body
            assign w_xi = r_x[gi-1];
            assign w_yi = r_y[gi-1];
            assign w_zi = r_z[gi-1];
            assign w_vi = r_vld[gi-1];
            assign w_ai = r_ang[gi-1];
        end

        assign w_at = $signed({1'b0, htm_pkg::atan_q30(gi)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ang[gi] <= w_ai;
                if (w_zi >= 0) begin
                    r_x[gi] <= w_xi - (w_yi >>> gi);
                    r_y[gi] <= w_yi + (w_xi >>> gi);
                    r_z[gi] <= w_zi - w_at;
                end else begin
                    r_x[gi] <= w_xi + (w_yi >>> gi);
                    r_y[gi] <= w_yi - (w_xi >>> gi);
                    r_z[gi] <= w_zi + w_at;
                end
            end
        end
    end

    logic signed [XW-1:0] w_xr;
    logic signed [XW-1:0] w_yr;
    logic signed [31:0]   w_c;
    logic signed [31:0]   w_s;
    logic                 w_flip;
    logic                 r_out_vld;
    htm_pkg::t_res        r_res;

    assign w_xr   = (r_x[N-1] + HALF) >>> SH;
    assign w_yr   = (r_y[N-1] + HALF) >>> SH;
    assign w_c    = 32'(w_xr);
    assign w_s    = 32'(w_yr);
    assign w_flip = r_ang[N-1].neg ^ ~r_ang[N-1].side.action[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.side  <= r_ang[N-1].side;
            r_res.sin_v <= w_flip ? -w_s : w_s;
            r_res.cos_v <= r_ang[N-1].cos_neg ? -w_c : w_c;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_res;

endmodule

// ===== hdl/htm_rowout.sv =====
// Holding register and row sequencer that issues the four matrix rows.
module htm_rowout #(
    parameter int FRAC_BITS = htm_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  htm_pkg::t_res i_res,
    output logic          o_take,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_row_index,
    output logic [31:0]   o_col_zero,
    output logic [31:0]   o_col_one,
    output logic [31:0]   o_col_two,
    output logic [31:0]   o_col_three,
    output logic          o_last_row
);

    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic            r_hold_vld;
    htm_pkg::t_res   r_hold;
    logic [1:0]      r_row;
    logic            r_out_vld;
    logic [1:0]      r_out_row;
    logic            r_out_last;
    logic [3:0][31:0] r_out_col;

    logic            w_load;
    logic            w_free;
    logic [31:0]     w_val;
    logic [31:0]     w_nsat;
    logic [3:0][31:0] n_col;
    logic            w_rot;
    logic [1:0]      w_ra;
    logic [1:0]      w_rb;

    assign w_load = r_hold_vld && (!r_out_vld || i_ready);
    assign w_free = !r_hold_vld || (w_load && (r_row == 2'd3));
    assign w_val  = r_hold.side.value;
    assign w_nsat = (w_val == 32'h8000_0000) ? 32'h7FFF_FFFF : (~w_val + 32'd1);

    always_comb begin
        w_rot = 1'b0;
        w_ra  = 2'd0;
        w_rb  = 2'd0;
        for (int j = 0; j < 4; j++) begin
            n_col[j] = (2'(j) == r_row) ? ONE : 32'd0;
        end
        case (r_hold.side.action) inside
            htm_pkg::ACT_MOVE_L, htm_pkg::ACT_MOVE_R, htm_pkg::ACT_MOVE_U,
            htm_pkg::ACT_MOVE_D, htm_pkg::ACT_MOVE_B, htm_pkg::ACT_MOVE_F: begin
                if (r_row == 2'd3) begin
                    n_col[r_hold.side.action[2:1]] = r_hold.side.action[0] ? w_val : w_nsat;
                end
            end
            htm_pkg::ACT_SCALE: begin
                if (r_row != 2'd3) begin
                    n_col[r_row] = w_val;
                end
            end
            htm_pkg::ACT_ROT_CW_X, htm_pkg::ACT_ROT_ACW_X: begin
                w_rot = 1'b1;
                w_ra  = 2'd1;
                w_rb  = 2'd2;
            end
            htm_pkg::ACT_ROT_CW_Y, htm_pkg::ACT_ROT_ACW_Y: begin
                w_rot = 1'b1;
                w_ra  = 2'd0;
                w_rb  = 2'd2;
            end
            htm_pkg::ACT_ROT_CW_Z, htm_pkg::ACT_ROT_ACW_Z: begin
                w_rot = 1'b1;
                w_ra  = 2'd0;
                w_rb  = 2'd1;
            end
            default: begin
            end
        endcase
        if (w_rot) begin
            if (r_row == w_ra) begin
                n_col[w_ra] = r_hold.cos_v;
                n_col[w_rb] = -r_hold.sin_v;
            end else if (r_row == w_rb) begin
                n_col[w_ra] = r_hold.sin_v;
                n_col[w_rb] = r_hold.cos_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_row      <= 2'd0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_free) begin
                r_hold_vld <= i_vld;
            end
            if (w_load) begin
                r_row     <= r_row + 2'd1;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && i_vld) begin
            r_hold <= i_res;
        end
        if (w_load) begin
            r_out_row  <= r_row;
            r_out_last <= (r_row == 2'd3);
            r_out_col  <= n_col;
        end
    end

    assign o_take      = w_free;
    assign o_valid     = r_out_vld;
    assign o_row_index = r_out_row;
    assign o_col_zero  = r_out_col[0];
    assign o_col_one   = r_out_col[1];
    assign o_col_two   = r_out_col[2];
    assign o_col_three = r_out_col[3];
    assign o_last_row  = r_out_last;

    a_row_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_ready && !r_out_last) |=>
        (r_out_vld && (r_out_row == $past(r_out_row) + 2'd1)))
        else $error("row sequence broken within a matrix");

    a_last_marks_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_last == (r_out_row == 2'd3)))
        else $error("last row flag does not match the row index");

    a_idle_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hold_vld |-> (r_row == 2'd0))
        else $error("row counter not at zero while the holding register is empty");

endmodule

// ===== hdl/homogeneous_transform_matrix_gen_core.sv =====
// Top level of the homogeneous 3D transform matrix generator.
// Each request (a transform kind and a Q16.16 amount) yields the 4x4 matrix for row
// vectors as four result rows, row 0 first, with the last row flagged. A request can
// be accepted in every cycle while the pipeline has room; the shared result port, which
// issues four rows per request, then limits the sustained rate. A request passes in turn
// through angle reduction, degree-to-radian conversion, the CORDIC stages, a rounding
// register, the holding register and the output register before its first row appears.
module homogeneous_transform_matrix_gen_core #(
    parameter int FRAC_BITS     = htm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = htm_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_action,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_row_index,
    output logic [31:0] o_col_zero,
    output logic [31:0] o_col_one,
    output logic [31:0] o_col_two,
    output logic [31:0] o_col_three,
    output logic        o_last_row
);

    logic                 w_en;
    logic                 w_take;
    htm_pkg::t_side       w_side;
    logic                 w_red_vld;
    htm_pkg::t_ang        w_red_ang;
    logic [FRAC_BITS+6:0] w_red_mag;
    logic                 w_rad_vld;
    htm_pkg::t_ang        w_rad_ang;
    logic [30:0]          w_rad_z;
    logic                 w_cor_vld;
    htm_pkg::t_res        w_cor_res;

    assign w_side.action = i_action;
    assign w_side.value  = i_value;
    assign w_en          = !w_cor_vld || w_take;
    assign o_ready       = w_en;

    htm_reduce #(
        .FRAC_BITS(FRAC_BITS)
    ) u_reduce (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (i_valid),
        .i_side (w_side),
        .o_vld  (w_red_vld),
        .o_ang  (w_red_ang),
        .o_mag  (w_red_mag)
    );

    htm_rad #(
        .FRAC_BITS(FRAC_BITS)
    ) u_rad (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_red_vld),
        .i_ang  (w_red_ang),
        .i_mag  (w_red_mag),
        .o_vld  (w_rad_vld),
        .o_ang  (w_rad_ang),
        .o_z    (w_rad_z)
    );

    htm_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_rad_vld),
        .i_ang  (w_rad_ang),
        .i_z    (w_rad_z),
        .o_vld  (w_cor_vld),
        .o_res  (w_cor_res)
    );

    htm_rowout #(
        .FRAC_BITS(FRAC_BITS)
    ) u_rowout (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_cor_vld),
        .i_res      (w_cor_res),
        .o_take     (w_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_row_index(o_row_index),
        .o_col_zero (o_col_zero),
        .o_col_one  (o_col_one),
        .o_col_two  (o_col_two),
        .o_col_three(o_col_three),
        .o_last_row (o_last_row)
    );

endmodule
